/* sv/uer_pkg.sv */
// ----------------------------------------------------------------------------
// uer_pkg: shared types and constants of the ultrasonic echo ranger
// Register codes, reset values, field widths and the structs that pass the
// measurement state and one result item between modules.
// ----------------------------------------------------------------------------
package uer_pkg;

    localparam int unsigned UER_TRIG_W        = 10;
    localparam int unsigned UER_LIM_W         = 16;
    localparam int unsigned UER_CNT_W         = 16;
    localparam int unsigned UER_DIST_W        = 16;
    localparam int unsigned UER_CFG_W         = 16;
    localparam int unsigned UER_CFG_IDX_W     = 2;
    localparam int unsigned UER_COUNTS_PER_CM = 145;

    localparam logic [UER_TRIG_W-1:0] UER_TRIG_RST    = 10'd10;
    localparam logic [UER_LIM_W-1:0]  UER_WAIT_RST    = 16'hFFFF;
    localparam logic [UER_LIM_W-1:0]  UER_MEASURE_RST = 16'd51456;

    typedef enum logic [UER_CFG_IDX_W-1:0] {
        CFG_TRIGGER_TICKS = 2'd0,
        CFG_WAIT_LIMIT    = 2'd1,
        CFG_MEASURE_LIMIT = 2'd2
    } uer_cfg_idx_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TRIG = 2'd1,
        PH_WAIT = 2'd2,
        PH_MEAS = 2'd3
    } uer_phase_t;

    typedef struct packed {
        logic [UER_TRIG_W-1:0] trigger_ticks;
        logic [UER_LIM_W-1:0]  wait_limit;
        logic [UER_LIM_W-1:0]  measure_limit;
    } uer_cfg_t;

    typedef struct packed {
        uer_phase_t            phase;
        logic [UER_CNT_W-1:0]  tick_count;
        logic [UER_DIST_W-1:0] last_distance;
    } uer_state_t;

    typedef struct packed {
        logic                  trig;
        logic                  busy;
        logic                  done;
        logic                  tout;
        logic [UER_DIST_W-1:0] distance;
    } uer_result_t;

endpackage

/* sv/uer_div.sv */
// ----------------------------------------------------------------------------
// uer_div: tick count to centimeters
// Divides the 16-bit echo count by a constant with one reciprocal multiply;
// the reciprocal is rounded up so the quotient is exact for every count.
// ----------------------------------------------------------------------------
module uer_div
    import uer_pkg::*;
#(
    parameter int unsigned COUNTS_PER_CM = UER_COUNTS_PER_CM
)
(
    input  logic [UER_CNT_W-1:0]  count,
    output logic [UER_DIST_W-1:0] quotient
);

    localparam int unsigned SHIFT   = UER_CNT_W + $clog2(COUNTS_PER_CM);
    localparam logic [63:0] RECIP64 =
        ((64'd1 << SHIFT) + 64'(COUNTS_PER_CM) - 64'd1) / 64'(COUNTS_PER_CM);
    localparam int unsigned RECIP_W = UER_CNT_W + 2;
    localparam int unsigned PROD_W  = UER_CNT_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP64[RECIP_W-1:0];

    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] shifted;

    assign prod     = {{RECIP_W{1'b0}}, count} * {{UER_CNT_W{1'b0}}, RECIP};
    assign shifted  = prod >> SHIFT;
    assign quotient = shifted[UER_DIST_W-1:0];

endmodule

/* sv/uer_step.sv */
// ----------------------------------------------------------------------------
// uer_step: one tick of the ranging sequence
// Next phase, tick count and reported distance, plus the result item, from
// the current state, the registered input item and the limit registers.
// ----------------------------------------------------------------------------
module uer_step
    import uer_pkg::*;
#(
    parameter int unsigned COUNTS_PER_CM = UER_COUNTS_PER_CM
)
(
    input  uer_state_t  cur_state,
    input  uer_cfg_t    cfg,
    input  logic        start_req,
    input  logic        echo,
    output uer_state_t  new_state,
    output uer_result_t result
);

    logic [UER_CNT_W-1:0]  trig_lim;
    logic [UER_CNT_W-1:0]  wait_lim;
    logic [UER_CNT_W-1:0]  meas_lim;
    logic [UER_CNT_W-1:0]  cnt_base;
    logic [UER_CNT_W-1:0]  cnt_inc;
    logic [UER_DIST_W-1:0] quot;
    uer_phase_t            ph;
    logic                  done;
    logic                  tout;

    // a zero limit acts as one
    assign trig_lim = (cfg.trigger_ticks == '0) ? UER_CNT_W'(1)
                                                : UER_CNT_W'(cfg.trigger_ticks);
    assign wait_lim = (cfg.wait_limit == '0) ? UER_CNT_W'(1) : cfg.wait_limit;
    assign meas_lim = (cfg.measure_limit == '0) ? UER_CNT_W'(1) : cfg.measure_limit;

    // a start in idle enters the trigger phase on this same tick
    assign ph       = (cur_state.phase == PH_IDLE && start_req) ? PH_TRIG
                                                                : cur_state.phase;
    assign cnt_base = (cur_state.phase == PH_IDLE) ? '0 : cur_state.tick_count;
    assign cnt_inc  = cnt_base + UER_CNT_W'(1);

    // distance on a falling echo uses the count before this tick
    uer_div #(
        .COUNTS_PER_CM (COUNTS_PER_CM)
    ) u_div (
        .count    (cur_state.tick_count),
        .quotient (quot)
    );

    always_comb
    begin
        new_state = cur_state;
        result    = '0;
        done      = 1'b0;
        tout      = 1'b0;

        case (ph)
            PH_TRIG:
            begin
                result.trig = 1'b1;
                result.busy = 1'b1;
                if (cnt_inc >= trig_lim)
                begin
                    new_state.phase      = PH_WAIT;
                    new_state.tick_count = '0;
                end
                else
                begin
                    new_state.phase      = PH_TRIG;
                    new_state.tick_count = cnt_inc;
                end
            end
            PH_WAIT:
            begin
                result.busy = 1'b1;
                if (echo)
                begin
                    new_state.phase      = PH_MEAS;
                    new_state.tick_count = UER_CNT_W'(1);
                    tout                 = (meas_lim == UER_CNT_W'(1));
                end
                else
                begin
                    new_state.tick_count = cnt_inc;
                    tout                 = (cnt_inc >= wait_lim);
                end
                done = tout;
            end
            PH_MEAS:
            begin
                result.busy = 1'b1;
                if (echo)
                begin
                    new_state.tick_count = cnt_inc;
                    tout                 = (cnt_inc >= meas_lim);
                    done                 = tout;
                end
                else
                begin
                    done = 1'b1;
                end
            end
            default:
            begin
                new_state.phase = PH_IDLE;
            end
        endcase

        if (done)
        begin
            new_state.last_distance = tout ? '0 : quot;
            new_state.phase         = PH_IDLE;
            new_state.tick_count    = '0;
            result.busy             = 1'b0;
        end

        result.done     = done;
        result.tout     = tout;
        result.distance = new_state.last_distance;
    end

endmodule

/* sv/ultrasonic_echo_ranger.sv */
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger: echo-time ultrasonic range finder
// One item per timer tick in, one result item per tick out.
// ----------------------------------------------------------------------------
// Each item is held in the input register, then in the result register.
// Throughput: 1 item per cycle while out_stall is low; the ranging step
//   and the constant divide settle between the input and result registers.
// Reset: rst_n clears phase to idle, count and distance to zero, and loads
//   the limit registers with their defaults; both pipeline stages empty.
module ultrasonic_echo_ranger
    import uer_pkg::*;
#(
    parameter int unsigned COUNTS_PER_CM = UER_COUNTS_PER_CM
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [UER_CFG_IDX_W-1:0] cfg_index,
    input  logic [UER_CFG_W-1:0]     cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     start_req,
    input  logic                     echo,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     trig,
    output logic                     busy_res,
    output logic                     done_res,
    output logic                     timed_out,
    output logic [UER_DIST_W-1:0]    distance_cm
);

    uer_cfg_t    cfg_reg;
    uer_state_t  state_reg;
    uer_state_t  state_next;
    uer_result_t res_next;
    uer_result_t res_reg;
    logic        s1_valid_reg;
    logic        s1_start_reg;
    logic        s1_echo_reg;
    logic        out_valid_reg;
    logic        accept;
    logic        advance;

    // the result register frees up when empty or when its item leaves
    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_ticks <= UER_TRIG_RST;
            cfg_reg.wait_limit    <= UER_WAIT_RST;
            cfg_reg.measure_limit <= UER_MEASURE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TRIGGER_TICKS: cfg_reg.trigger_ticks <= cfg_data[UER_TRIG_W-1:0];
                CFG_WAIT_LIMIT:    cfg_reg.wait_limit    <= cfg_data[UER_LIM_W-1:0];
                CFG_MEASURE_LIMIT: cfg_reg.measure_limit <= cfg_data[UER_LIM_W-1:0];
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    uer_step #(
        .COUNTS_PER_CM (COUNTS_PER_CM)
    ) u_step (
        .cur_state (state_reg),
        .cfg       (cfg_reg),
        .start_req (s1_start_reg),
        .echo      (s1_echo_reg),
        .new_state (state_next),
        .result    (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{phase: PH_IDLE, tick_count: '0, last_distance: '0};
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            // state moves with the item that leaves the input register
            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_start_reg <= start_req;
            s1_echo_reg  <= echo;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign trig        = res_reg.trig;
    assign busy_res    = res_reg.busy;
    assign done_res    = res_reg.done;
    assign timed_out   = res_reg.tout;
    assign distance_cm = res_reg.distance;

endmodule

/* sv/uer_checker.sv */
// ----------------------------------------------------------------------------
// uer_checker: port-level checks of the ultrasonic echo ranger
// Watches the result channel and attaches to the top level by bind.
// ----------------------------------------------------------------------------
module uer_checker
    import uer_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic                  trig,
    input logic                  busy_res,
    input logic                  done_res,
    input logic                  timed_out,
    input logic [UER_DIST_W-1:0] distance_cm
);

    // hold a stalled result item
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(distance_cm)
            && $stable(done_res) && $stable(timed_out) && $stable(trig))
        else $error("stalled result item changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && timed_out |-> done_res && distance_cm == '0)
        else $error("timeout without done or with nonzero distance");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !busy_res && !trig)
        else $error("finishing item still busy or triggering");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && trig |-> busy_res)
        else $error("trigger driven outside a measurement");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .trig        (trig),
    .busy_res    (busy_res),
    .done_res    (done_res),
    .timed_out   (timed_out),
    .distance_cm (distance_cm)
);

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for ultrasonic_echo_ranger
// Drives timer ticks (start request, echo level) with random idle gaps and
// output stalls, predicts every result item in a local model of the ranging
// state machine, and compares each result field by field. A directed plan
// covers reset values, register masking, zero limits, both timeouts and
// ignored starts; random register settings and measurement sequences follow.
// ----------------------------------------------------------------------------
module testbench;
    import uer_pkg::*;

    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic          is_cfg;
        uer_cfg_idx_t  idx;
        logic [15:0]   data;
        logic          req;
        logic          echo_lvl;
        logic          typed;
        uer_result_t   want;
    } stim_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [UER_CFG_IDX_W-1:0] cfg_index = CFG_TRIGGER_TICKS;
    logic [UER_CFG_W-1:0]     cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic                     start_req = 1'b0;
    logic                     echo = 1'b0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic                     trig;
    logic                     busy_res;
    logic                     done_res;
    logic                     timed_out;
    logic [UER_DIST_W-1:0]    distance_cm;

    // local copy of the ranger state and its registers
    uer_phase_t       ph;
    logic [15:0]      ticks;
    logic [15:0]      range_cm;
    logic [9:0]       cfg_trig;
    logic [15:0]      cfg_wait;
    logic [15:0]      cfg_meas;

    uer_result_t      range_q[$];
    stim_row_t        plan[$];
    uer_result_t      got_res;
    uer_result_t      want_res;

    int err_count = 0;
    int tick_total = 0;
    int result_total = 0;
    int write_total = 0;
    int fall_count = 0;
    int ranged_count = 0;
    int tout_count = 0;
    int in_mode = 1;
    int out_mode = 1;

    logic [15:0] trig_set [0:5] = '{16'd10, 16'd1, 16'd24, 16'd4, 16'hFC06, 16'd2};
    logic [15:0] wait_set [0:5] = '{16'hFFFF, 16'd1, 16'd30, 16'd20, 16'd0, 16'hFFFF};
    logic [15:0] meas_set [0:5] = '{16'd51456, 16'd1, 16'd300, 16'd200, 16'd0, 16'hFFFF};

    ultrasonic_echo_ranger u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .start_req   (start_req),
        .echo        (echo),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .trig        (trig),
        .busy_res    (busy_res),
        .done_res    (done_res),
        .timed_out   (timed_out),
        .distance_cm (distance_cm)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic rbit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic int draw_wait(input int mode);
        if (mode == 0)
            return 0;
        if (mode == 1)
            return $urandom_range(0, 18);
        return ($urandom_range(0, 5) == 0) ? $urandom_range(1, 18) : 0;
    endfunction

    function automatic uer_result_t outcome(input logic t, input logic b, input logic d,
                                            input logic o);
        uer_result_t r;
        r = '0;
        r.trig = t;
        r.busy = b;
        r.done = d;
        r.tout = o;
        return r;
    endfunction

    function automatic stim_row_t tick_row(input logic s, input logic e);
        stim_row_t r;
        r = '0;
        r.req = s;
        r.echo_lvl = e;
        return r;
    endfunction

    function automatic stim_row_t tick_check(input logic s, input logic e,
                                             input uer_result_t w);
        stim_row_t r;
        r = tick_row(s, e);
        r.typed = 1'b1;
        r.want = w;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(input uer_cfg_idx_t idx, input logic [15:0] d);
        stim_row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.data = d;
        return r;
    endfunction

    // one timer tick of the ranging state machine
    function automatic uer_result_t ranger_tick(input logic s, input logic e);
        uer_result_t r;
        logic [15:0] trig_lim;
        logic [15:0] wait_lim;
        logic [15:0] meas_lim;
        r = '0;
        trig_lim = (cfg_trig == '0) ? 16'd1 : {6'd0, cfg_trig};
        wait_lim = (cfg_wait == '0) ? 16'd1 : cfg_wait;
        meas_lim = (cfg_meas == '0) ? 16'd1 : cfg_meas;
        if (ph == PH_IDLE && s)
        begin
            ph = PH_TRIG;
            ticks = '0;
        end
        case (ph)
            PH_TRIG:
            begin
                r.trig = 1'b1;
                r.busy = 1'b1;
                ticks = ticks + 16'd1;
                if (ticks >= trig_lim)
                begin
                    ph = PH_WAIT;
                    ticks = '0;
                end
            end
            PH_WAIT:
            begin
                r.busy = 1'b1;
                if (e)
                begin
                    // the rising tick is the first measured tick
                    ph = PH_MEAS;
                    ticks = 16'd1;
                    if (ticks >= meas_lim)
                    begin
                        r.done = 1'b1;
                        r.tout = 1'b1;
                    end
                end
                else
                begin
                    ticks = ticks + 16'd1;
                    if (ticks >= wait_lim)
                    begin
                        r.done = 1'b1;
                        r.tout = 1'b1;
                    end
                end
            end
            PH_MEAS:
            begin
                r.busy = 1'b1;
                if (e)
                begin
                    ticks = ticks + 16'd1;
                    if (ticks >= meas_lim)
                    begin
                        r.done = 1'b1;
                        r.tout = 1'b1;
                    end
                end
                else
                    r.done = 1'b1;
            end
            default: ;
        endcase
        if (r.done)
        begin
            range_cm = r.tout ? 16'd0 : 16'(ticks / 16'(UER_COUNTS_PER_CM));
            ph = PH_IDLE;
            ticks = '0;
            r.busy = 1'b0;
        end
        r.distance = range_cm;
        return r;
    endfunction

    task automatic flag_result(input string what, input uer_result_t want,
                               input uer_result_t got);
        err_count++;
        if (err_count <= 10)
        begin
            $display("%0t %s: expected trig=%0b busy=%0b done=%0b tout=%0b dist=%0d,",
                     $time, what, want.trig, want.busy, want.done, want.tout,
                     want.distance);
            $display("    got trig=%0b busy=%0b done=%0b tout=%0b dist=%0d",
                     got.trig, got.busy, got.done, got.tout, got.distance);
        end
    endtask

    // hold the item until accepted, then record its expected result
    task automatic send_tick(input logic s, input logic e, input logic typed,
                             input uer_result_t want);
        int gap;
        uer_result_t pred;
        gap = draw_wait(in_mode);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        start_req <= s;
        echo <= e;
        do
            @(posedge clk);
        while (in_stall);
        pred = ranger_tick(s, e);
        range_q.push_back(typed ? want : pred);
        tick_total++;
        if (pred.done)
        begin
            if (pred.tout)
                tout_count++;
            else
            begin
                fall_count++;
                if (pred.distance != '0)
                    ranged_count++;
            end
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (range_q.size() != 0);
    endtask

    task automatic write_reg(input uer_cfg_idx_t idx, input logic [15:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_TRIGGER_TICKS: cfg_trig = data[9:0];
            CFG_WAIT_LIMIT:    cfg_wait = data;
            CFG_MEASURE_LIMIT: cfg_meas = data;
            default: ;
        endcase
        write_total++;
    endtask

    // start, trigger, wait for echo, measure, with random content
    task automatic measure_once();
        int wait_len;
        int high_len;
        int k;
        int pick;
        send_tick(1'b1, rbit(), 1'b0, '0);
        while (ph == PH_TRIG)
            send_tick(rbit(), rbit(), 1'b0, '0);
        if (cfg_wait <= 16'd60 && $urandom_range(0, 3) == 0)
            wait_len = 70000;
        else
            wait_len = $urandom_range(0, 12);
        k = 0;
        while (ph == PH_WAIT && k < wait_len)
        begin
            send_tick(rbit(), 1'b0, 1'b0, '0);
            k++;
        end
        if (ph == PH_WAIT)
            send_tick(rbit(), 1'b1, 1'b0, '0);
        pick = $urandom_range(0, 19);
        if (pick < 3 && cfg_meas <= 16'd400)
            high_len = 70000;
        else if (pick < 6)
            high_len = $urandom_range(145, 330);
        else
            high_len = $urandom_range(1, 8);
        k = 1;
        while (ph == PH_MEAS && k < high_len)
        begin
            send_tick(rbit(), 1'b1, 1'b0, '0);
            k++;
        end
        if (ph == PH_MEAS)
            send_tick(rbit(), 1'b0, 1'b0, '0);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            got_res.trig = trig;
            got_res.busy = busy_res;
            got_res.done = done_res;
            got_res.tout = timed_out;
            got_res.distance = distance_cm;
            result_total++;
            if (range_q.size() == 0)
                flag_result("result with nothing pending", '0, got_res);
            else
            begin
                want_res = range_q.pop_front();
                if (got_res.trig !== want_res.trig || got_res.busy !== want_res.busy ||
                    got_res.done !== want_res.done || got_res.tout !== want_res.tout ||
                    got_res.distance !== want_res.distance)
                    flag_result("result mismatch", want_res, got_res);
            end
        end
    end

    // receiver: stall a random number of cycles before each result item
    initial
    begin
        int n;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            n = draw_wait(out_mode);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        wait (rst_n);
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("** ultrasonic_echo_ranger: FAILED **");
        $finish;
    end

    initial
    begin
        logic [15:0] t;
        logic [15:0] w;
        logic [15:0] m;
        int phase_end;
        ph = PH_IDLE;
        ticks = '0;
        range_cm = '0;
        cfg_trig = UER_TRIG_RST;
        cfg_wait = UER_WAIT_RST;
        cfg_meas = UER_MEASURE_RST;

        plan.push_back(tick_check(1'b0, 1'b0, outcome(1'b0, 1'b0, 1'b0, 1'b0)));
        plan.push_back(tick_check(1'b0, 1'b1, outcome(1'b0, 1'b0, 1'b0, 1'b0)));
        // upper bits of the trigger register are dropped
        plan.push_back(cfg_row(CFG_TRIGGER_TICKS, 16'hFC01));
        plan.push_back(cfg_row(CFG_WAIT_LIMIT, 16'd2));
        plan.push_back(cfg_row(CFG_MEASURE_LIMIT, 16'd1));
        plan.push_back(tick_check(1'b1, 1'b0, outcome(1'b1, 1'b1, 1'b0, 1'b0)));
        // echo rise hits a measure limit of one; the start is ignored
        plan.push_back(tick_check(1'b1, 1'b1, outcome(1'b0, 1'b0, 1'b1, 1'b1)));
        plan.push_back(tick_check(1'b1, 1'b0, outcome(1'b1, 1'b1, 1'b0, 1'b0)));
        plan.push_back(tick_check(1'b0, 1'b0, outcome(1'b0, 1'b1, 1'b0, 1'b0)));
        plan.push_back(tick_check(1'b0, 1'b0, outcome(1'b0, 1'b0, 1'b1, 1'b1)));
        // zero limits act as one
        plan.push_back(cfg_row(CFG_TRIGGER_TICKS, 16'd0));
        plan.push_back(cfg_row(CFG_WAIT_LIMIT, 16'd0));
        plan.push_back(cfg_row(CFG_MEASURE_LIMIT, 16'd0));
        plan.push_back(tick_check(1'b1, 1'b0, outcome(1'b1, 1'b1, 1'b0, 1'b0)));
        plan.push_back(tick_check(1'b0, 1'b0, outcome(1'b0, 1'b0, 1'b1, 1'b1)));
        plan.push_back(tick_row(1'b1, 1'b0));
        plan.push_back(tick_row(1'b0, 1'b1));
        plan.push_back(cfg_row(CFG_TRIGGER_TICKS, 16'd3));
        plan.push_back(cfg_row(CFG_WAIT_LIMIT, 16'hFFFF));
        plan.push_back(cfg_row(CFG_MEASURE_LIMIT, 16'hFFFF));
        plan.push_back(tick_row(1'b1, 1'b1));
        plan.push_back(tick_row(1'b0, 1'b0));
        plan.push_back(tick_row(1'b1, 1'b1));
        plan.push_back(tick_row(1'b0, 1'b0));
        plan.push_back(tick_row(1'b0, 1'b1));
        plan.push_back(tick_row(1'b1, 1'b1));
        // echo falls with a start request on the same tick
        plan.push_back(tick_row(1'b1, 1'b0));
        plan.push_back(cfg_row(CFG_MEASURE_LIMIT, 16'd2));
        plan.push_back(tick_row(1'b1, 1'b0));
        plan.push_back(tick_row(1'b0, 1'b1));
        plan.push_back(tick_row(1'b0, 1'b0));
        plan.push_back(tick_row(1'b0, 1'b1));
        plan.push_back(tick_check(1'b0, 1'b1, outcome(1'b0, 1'b0, 1'b1, 1'b1)));
        plan.push_back(tick_row(1'b0, 1'b1));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                drain_results();
                write_reg(plan[i].idx, plan[i].data);
            end
            else
                send_tick(plan[i].req, plan[i].echo_lvl, plan[i].typed, plan[i].want);
        end

        for (int p = 0; p < 8; p++)
        begin
            if (p < 6)
            begin
                t = trig_set[p];
                w = wait_set[p];
                m = meas_set[p];
            end
            else
            begin
                t = 16'($urandom_range(1, 12));
                w = 16'($urandom_range(1, 40));
                m = 16'($urandom_range(1, 400));
            end
            // hold off until every pending result has come back
            drain_results();
            write_reg(CFG_TRIGGER_TICKS, t);
            write_reg(CFG_WAIT_LIMIT, w);
            write_reg(CFG_MEASURE_LIMIT, m);
            in_mode = (p == 1) ? 0 : $urandom_range(0, 2);
            out_mode = (p == 1) ? 0 : $urandom_range(0, 2);
            phase_end = tick_total + ((p == 2) ? 1 : 40);
            while (tick_total < phase_end)
            begin
                if ($urandom_range(0, 4) != 0)
                    measure_once();
                else
                    repeat ($urandom_range(1, 6))
                        send_tick(1'($urandom_range(0, 7) == 0), rbit(), 1'b0, '0);
            end
            // finish any measurement still open
            while (ph != PH_IDLE)
                send_tick(1'b0, ph == PH_WAIT, 1'b0, '0);
        end

        drain_results();
        // allow for the input and result registers
        repeat (20) @(posedge clk);
        if (range_q.size() != 0)
        begin
            $display("%0d result items never arrived", range_q.size());
            err_count += range_q.size();
        end

        $display("Ran %0d ticks and checked %0d results across %0d register writes.",
                 tick_total, result_total, write_total);
        $display("Echo-fall readings: %0d (%0d nonzero); timeouts: %0d; errors: %0d.",
                 fall_count, ranged_count, tout_count, err_count);
        if (err_count == 0)
            $display("** ultrasonic_echo_ranger: PASSED **");
        else
            $display("** ultrasonic_echo_ranger: FAILED **");
        $finish;
    end

endmodule

/* sim.f */
sv/uer_pkg.sv
sv/uer_div.sv
sv/uer_step.sv
sv/ultrasonic_echo_ranger.sv
sv/uer_checker.sv
tb/testbench.sv
